FILE: hdl/lts_pkg.sv
`timescale 1ns / 1ps

package lts_pkg;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [22:0]        LOOKAHEAD_RESET = 23'd8192;
    localparam logic [22:0]        DIST_MAX        = 23'h7F_FFFF;
    localparam logic [15:0]        ANGLE_90_Q88    = 16'd23040;
    localparam logic signed [24:0] ANGLE_90_Q16    = 25'sd5898240;
    localparam logic signed [31:0] SLOPE_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SLOPE_MIN       = 32'sh8000_0000;

    localparam int ATAN_ENTRIES = 24;

    // Arctangent of 2^-i in degrees, Q.16.
    localparam logic [22:0] ATAN_DEG_Q16 [ATAN_ENTRIES] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
        23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
    };

    typedef struct packed {
        logic signed [23:0] end_point_y;
        logic signed [23:0] way_point_y;
        logic signed [23:0] end_point_x;
        logic signed [23:0] way_point_x;
        logic signed [23:0] robot_y;
        logic signed [23:0] robot_x;
    } lts_in_t;

    typedef struct packed {
        logic signed [15:0] turn_angle;
        logic [22:0]        line_distance;
        logic               status;
    } lts_out_t;

    typedef struct packed {
        logic [23:0]        dy_abs;
        logic [23:0]        dx_abs;
        logic               m_neg;
        logic               vert;
        logic signed [24:0] ax;
        logic signed [24:0] ey;
    } lts_mid_t;

    typedef struct packed {
        logic               sat;
        logic               m_neg;
        logic               vert;
        logic signed [24:0] ax;
        logic signed [24:0] ey;
    } lts_s1_t;

    typedef struct packed {
        logic sat;
        logic vert;
    } lts_s2_t;

    typedef struct packed {
        logic        vert;
        logic        dist_zero;
        logic        look_zero;
        logic [22:0] line_dist;
    } lts_flag_t;

endpackage

FILE: hdl/lts_queue.sv
`timescale 1ns / 1ps

module lts_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

FILE: hdl/lts_front.sv
`timescale 1ns / 1ps

module lts_front
    import lts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lts_in_t  in_data,
    output logic     full,
    input  logic     mq_full,
    output logic     mq_wr,
    output lts_mid_t mq_data
);

    logic               valid_reg;
    lts_mid_t           data_reg;
    lts_mid_t           data_next;
    logic signed [24:0] dy;
    logic signed [24:0] dx;

    assign full    = valid_reg && mq_full;
    assign mq_wr   = valid_reg && !mq_full;
    assign mq_data = data_reg;

    always_comb
    begin
        dy = {in_data.end_point_y[23], in_data.end_point_y}
           - {in_data.way_point_y[23], in_data.way_point_y};
        dx = {in_data.end_point_x[23], in_data.end_point_x}
           - {in_data.way_point_x[23], in_data.way_point_x};
        data_next.dy_abs = dy[24] ? 24'(-dy) : dy[23:0];
        data_next.dx_abs = dx[24] ? 24'(-dx) : dx[23:0];
        data_next.m_neg  = dy[24] ^ dx[24];
        data_next.vert   = (dx == '0);
        data_next.ax     = {in_data.robot_x[23], in_data.robot_x}
                         - {in_data.way_point_x[23], in_data.way_point_x};
        data_next.ey     = {in_data.way_point_y[23], in_data.way_point_y}
                         - {in_data.robot_y[23], in_data.robot_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!full)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!full)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hdl/lts_div.sv
`timescale 1ns / 1ps

module lts_div #(
    parameter int DW = 24,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] low_bits,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] bits_reg  [QW];
    logic [DW-1:0] div_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic          v_in;
        logic [DW-1:0] r_in;
        logic [QW-1:0] b_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] bits_next;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = rem_init;
            assign b_in = low_bits;
            assign d_in = divisor;
            assign s_in = side_in;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign b_in = bits_reg[k-1];
            assign d_in = div_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        always_comb
        begin
            t         = {r_in, b_in[QW-1]};
            diff      = t - {1'b0, d_in};
            ge        = (t >= {1'b0, d_in});
            rem_next  = ge ? diff[DW-1:0] : t[DW-1:0];
            bits_next = {b_in[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                bits_reg[k] <= bits_next;
                div_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quotient  = bits_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

FILE: hdl/lts_back.sv
`timescale 1ns / 1ps

module lts_back
    import lts_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [22:0] lookahead,
    input  logic        mq_empty,
    input  lts_mid_t    mq_data,
    output logic        mq_pop,
    input  logic        oq_full,
    output logic        oq_wr,
    output lts_out_t    oq_data
);

    localparam int NI = CORDIC_ITERATIONS;

    logic adv;

    // Slope division.
    lts_s1_t     d1_side_in;
    logic [52:0] d1_side_vec;
    lts_s1_t     d1_side_out;
    logic        d1_valid;
    logic [30:0] d1_q;

    logic               s1_valid_reg;
    logic signed [31:0] m_reg;
    logic signed [24:0] s1_ax_reg;
    logic signed [24:0] s1_ey_reg;
    logic               s1_vert_reg;
    logic signed [31:0] m_next;

    logic               s2_valid_reg;
    logic signed [56:0] prod_reg;
    logic [63:0]        msq_reg;
    logic signed [24:0] s2_ey_reg;
    logic               s2_vert_reg;

    logic               s3_valid_reg;
    logic signed [56:0] r_reg;
    logic [63:0]        sq_reg;
    logic               s3_vert_reg;
    logic [55:0]        mag_abs;

    // Square root stages.
    logic        sq_valid_reg [32];
    logic [35:0] sq_rem_reg   [32];
    logic [31:0] sq_root_reg  [32];
    logic [63:0] sq_rad_reg   [32];
    logic [55:0] sq_mag_reg   [32];
    logic        sq_vert_reg  [32];

    logic        s5_valid_reg;
    lts_s2_t     s5_side_reg;
    logic [31:0] s5_rem_reg;
    logic [22:0] s5_low_reg;
    logic [31:0] s5_s_reg;

    logic [1:0]  d2_side_vec;
    lts_s2_t     d2_side_out;
    logic        d2_valid;
    logic [22:0] d2_q;

    logic        dd_valid_reg;
    logic [22:0] dist_reg;
    logic        dd_vert_reg;

    logic        n1_valid_reg;
    logic [4:0]  n1_sh_reg;
    lts_flag_t   n1_flag_reg;
    logic [22:0] n1_look_reg;
    logic [22:0] n1_or;
    logic [4:0]  n1_msb;
    logic [4:0]  n1_sh;

    logic               n2_valid_reg;
    logic signed [33:0] n2_x_reg;
    logic signed [33:0] n2_y_reg;
    lts_flag_t          n2_flag_reg;

    logic               cv_reg [NI];
    logic signed [33:0] cx_reg [NI];
    logic signed [33:0] cy_reg [NI];
    logic signed [24:0] cz_reg [NI];
    lts_flag_t          cf_reg [NI];

    logic               f_valid_reg;
    lts_out_t           f_out_reg;
    lts_out_t           f_out_next;
    logic signed [24:0] zc;
    logic signed [24:0] zr;

    assign adv    = !(f_valid_reg && oq_full);
    assign mq_pop = adv && !mq_empty;
    assign oq_wr  = adv && f_valid_reg;
    assign oq_data = f_out_reg;

    always_comb
    begin
        d1_side_in.sat   = ({15'd0, mq_data.dy_abs[23:15]} >= mq_data.dx_abs);
        d1_side_in.m_neg = mq_data.m_neg;
        d1_side_in.vert  = mq_data.vert;
        d1_side_in.ax    = mq_data.ax;
        d1_side_in.ey    = mq_data.ey;
    end

    lts_div #(
        .DW (24),
        .QW (31),
        .SW ($bits(lts_s1_t))
    ) u_slope_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (mq_pop),
        .rem_init  ({15'd0, mq_data.dy_abs[23:15]}),
        .low_bits  ({mq_data.dy_abs[14:0], 16'd0}),
        .divisor   (mq_data.dx_abs),
        .side_in   (d1_side_in),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .side_out  (d1_side_vec)
    );

    assign d1_side_out = lts_s1_t'(d1_side_vec);

    always_comb
    begin
        if (d1_side_out.sat)
        begin
            m_next = d1_side_out.m_neg ? SLOPE_MIN : SLOPE_MAX;
        end
        else if (d1_side_out.m_neg)
        begin
            m_next = -$signed({1'b0, d1_q});
        end
        else
        begin
            m_next = $signed({1'b0, d1_q});
        end
    end

    assign mag_abs = r_reg[56] ? 56'(-r_reg) : r_reg[55:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            dd_valid_reg <= 1'b0;
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
            f_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= d1_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s5_valid_reg <= sq_valid_reg[31];
            dd_valid_reg <= d2_valid;
            n1_valid_reg <= dd_valid_reg;
            n2_valid_reg <= n1_valid_reg;
            f_valid_reg  <= cv_reg[NI-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg       <= m_next;
            s1_ax_reg   <= d1_side_out.ax;
            s1_ey_reg   <= d1_side_out.ey;
            s1_vert_reg <= d1_side_out.vert;

            prod_reg    <= 57'(m_reg) * 57'(s1_ax_reg);
            msq_reg     <= 64'(m_reg) * 64'(m_reg);
            s2_ey_reg   <= s1_ey_reg;
            s2_vert_reg <= s1_vert_reg;

            r_reg       <= prod_reg + {{16{s2_ey_reg[24]}}, s2_ey_reg, 16'd0};
            sq_reg      <= msq_reg + 64'h1_0000_0000;
            s3_vert_reg <= s2_vert_reg;
        end
    end

    for (genvar k = 0; k < 32; k++)
    begin : g_sqrt
        logic        v_in;
        logic [35:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [55:0] mag_in;
        logic        vert_in;
        logic [35:0] t;
        logic [35:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign v_in    = s3_valid_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = sq_reg;
            assign mag_in  = mag_abs;
            assign vert_in = s3_vert_reg;
        end
        else
        begin : g_rest
            assign v_in    = sq_valid_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign rad_in  = sq_rad_reg[k-1];
            assign mag_in  = sq_mag_reg[k-1];
            assign vert_in = sq_vert_reg[k-1];
        end

        always_comb
        begin
            t     = {rem_in[33:0], rad_in[63:62]};
            trial = {2'b00, root_in, 2'b01};
            ge    = (t >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k]  <= ge ? (t - trial) : t;
                sq_root_reg[k] <= {root_in[30:0], ge};
                sq_rad_reg[k]  <= {rad_in[61:0], 2'b00};
                sq_mag_reg[k]  <= mag_in;
                sq_vert_reg[k] <= vert_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg.sat  <= (sq_mag_reg[31][55:23] >= {1'b0, sq_root_reg[31]});
            s5_side_reg.vert <= sq_vert_reg[31];
            s5_rem_reg       <= sq_mag_reg[31][54:23];
            s5_low_reg       <= sq_mag_reg[31][22:0];
            s5_s_reg         <= sq_root_reg[31];
        end
    end

    lts_div #(
        .DW (32),
        .QW (23),
        .SW ($bits(lts_s2_t))
    ) u_dist_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s5_valid_reg),
        .rem_init  (s5_rem_reg),
        .low_bits  (s5_low_reg),
        .divisor   (s5_s_reg),
        .side_in   (s5_side_reg),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .side_out  (d2_side_vec)
    );

    assign d2_side_out = lts_s2_t'(d2_side_vec);

    always_comb
    begin
        n1_or  = dist_reg | lookahead;
        n1_msb = '0;
        for (int b = 0; b < 23; b++)
        begin
            if (n1_or[b])
            begin
                n1_msb = 5'(b);
            end
        end
        n1_sh = (n1_or == '0) ? 5'd0 : (5'd30 - n1_msb);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (d2_side_out.vert)
            begin
                dist_reg <= '0;
            end
            else if (d2_side_out.sat)
            begin
                dist_reg <= DIST_MAX;
            end
            else
            begin
                dist_reg <= d2_q;
            end
            dd_vert_reg <= d2_side_out.vert;

            n1_sh_reg             <= n1_sh;
            n1_look_reg           <= lookahead;
            n1_flag_reg.vert      <= dd_vert_reg;
            n1_flag_reg.dist_zero <= (dist_reg == '0);
            n1_flag_reg.look_zero <= (lookahead == '0);
            n1_flag_reg.line_dist <= dist_reg;

            n2_x_reg    <= $signed({11'd0, n1_flag_reg.line_dist}) <<< n1_sh_reg;
            n2_y_reg    <= $signed({11'd0, n1_look_reg}) <<< n1_sh_reg;
            n2_flag_reg <= n1_flag_reg;
        end
    end

    for (genvar i = 0; i < NI; i++)
    begin : g_cordic
        logic               v_in;
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [24:0] z_in;
        lts_flag_t          f_in;
        logic signed [24:0] a;

        if (i == 0)
        begin : g_first
            assign v_in = n2_valid_reg;
            assign x_in = n2_x_reg;
            assign y_in = n2_y_reg;
            assign z_in = '0;
            assign f_in = n2_flag_reg;
        end
        else
        begin : g_rest
            assign v_in = cv_reg[i-1];
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign f_in = cf_reg[i-1];
        end

        assign a = $signed({2'b00, ATAN_DEG_Q16[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                cv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (y_in > 0)
                begin
                    cx_reg[i] <= x_in + (y_in >>> i);
                    cy_reg[i] <= y_in - (x_in >>> i);
                    cz_reg[i] <= z_in + a;
                end
                else
                begin
                    cx_reg[i] <= x_in - (y_in >>> i);
                    cy_reg[i] <= y_in + (x_in >>> i);
                    cz_reg[i] <= z_in - a;
                end
                cf_reg[i] <= f_in;
            end
        end
    end

    always_comb
    begin
        if (cz_reg[NI-1] < 0)
        begin
            zc = '0;
        end
        else if (cz_reg[NI-1] > ANGLE_90_Q16)
        begin
            zc = ANGLE_90_Q16;
        end
        else
        begin
            zc = cz_reg[NI-1];
        end
        zr = (zc + 25'sd128) >>> 8;

        f_out_next.line_distance = cf_reg[NI-1].line_dist;
        f_out_next.status        = 1'b0;
        if (cf_reg[NI-1].vert)
        begin
            f_out_next.turn_angle    = '0;
            f_out_next.line_distance = '0;
            f_out_next.status        = 1'b1;
        end
        else if (cf_reg[NI-1].dist_zero)
        begin
            f_out_next.turn_angle = $signed(ANGLE_90_Q88);
        end
        else if (cf_reg[NI-1].look_zero)
        begin
            f_out_next.turn_angle = '0;
        end
        else
        begin
            f_out_next.turn_angle = zr[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_out_reg <= f_out_next;
        end
    end

endmodule

FILE: hdl/line_tracking_steer_angle.sv
// Line-tracking steering angle unit.
// Input words arrive on in_data with push; a word is taken when push is high and
// full is low. Each word holds an end point, a way point and the robot position.
// Every input word produces exactly one result word on out_data, held while empty
// is low and removed when pop is high. Results leave in input order.
// The user writes the lookahead length through cfg_wr_en and cfg_wr_data while
// the unit is idle; the block does not enforce this. It resets to 2.0 in Q11.12.
// Throughput is one word per cycle while the receiver takes results. The path
// from accepted input to visible result runs through the 31-step slope divider,
// the 32-step square root, the 23-step distance divider and the CORDIC stages.
// When the receiver stalls, the output queue fills and the whole back pipeline
// holds; the middle queue then fills and full rises. No word is lost.
// Reset clears all queues and pipeline valid flags.
`timescale 1ns / 1ps

module line_tracking_steer_angle
    import lts_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lts_in_t     in_data,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output lts_out_t    out_data,
    input  logic        cfg_wr_en,
    input  logic [22:0] cfg_wr_data
);

    logic [22:0] lookahead_reg;

    logic                         mq_wr;
    lts_mid_t                     mq_wdata;
    logic                         mq_full;
    logic                         mq_empty;
    logic                         mq_pop;
    logic [$bits(lts_mid_t)-1:0]  mq_rdata_vec;
    lts_mid_t                     mq_rdata;

    logic                         oq_wr;
    lts_out_t                     oq_wdata;
    logic                         oq_full;
    logic [$bits(lts_out_t)-1:0]  oq_rdata_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg <= LOOKAHEAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            lookahead_reg <= cfg_wr_data;
        end
    end

    lts_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_data (in_data),
        .full    (full),
        .mq_full (mq_full),
        .mq_wr   (mq_wr),
        .mq_data (mq_wdata)
    );

    lts_queue #(
        .W     ($bits(lts_mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mq_wr),
        .wdata (mq_wdata),
        .full  (mq_full),
        .rd    (mq_pop),
        .rdata (mq_rdata_vec),
        .empty (mq_empty)
    );

    assign mq_rdata = lts_mid_t'(mq_rdata_vec);

    lts_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookahead (lookahead_reg),
        .mq_empty  (mq_empty),
        .mq_data   (mq_rdata),
        .mq_pop    (mq_pop),
        .oq_full   (oq_full),
        .oq_wr     (oq_wr),
        .oq_data   (oq_wdata)
    );

    lts_queue #(
        .W     ($bits(lts_out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (oq_wr),
        .wdata (oq_wdata),
        .full  (oq_full),
        .rd    (pop),
        .rdata (oq_rdata_vec),
        .empty (empty)
    );

    assign out_data = lts_out_t'(oq_rdata_vec);

`ifndef NO_ASSERTIONS
    a_vert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_data.status) |->
        (out_data.turn_angle == '0 && out_data.line_distance == '0))
        else $error("vertical line result carries nonzero outputs");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!out_data.turn_angle[15] &&
                    out_data.turn_angle[14:0] <= ANGLE_90_Q88[14:0]))
        else $error("turn angle outside 0 to 90 degrees");

    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> mq_full)
        else $error("front stalls while the middle queue has room");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("waiting result word changed before it was taken");
`endif

endmodule
